>>> sv/kaqd_pkg.sv
package kaqd_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;

  localparam int KEY_W    = 64;
  localparam int HPORT_W  = 16;
  localparam int QPORT_W  = 3;
  localparam int ACT_W    = 4;
  localparam int ACT_RESET = 4;

  // internal widths
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SPAN_W = $clog2(NUM_QUEUES + 1);
  localparam int HS_W   = (HANDLE_BITS < HPORT_W) ? HANDLE_BITS : HPORT_W;
  localparam int ROW_W  = QUEUE_DEPTH * KEY_W;
  localparam int HA_W   = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO_KEY = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_MIN,
    S_INSERT,
    S_RESP
  } state_t;

  // per-queue ring pointers
  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } qstate_t;

endpackage

>>> sv/kaqd_ram.sv
module kaqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/kaqd_match.sv
module kaqd_match (
  input  logic [kaqd_pkg::ROW_W-1:0] row,
  input  logic [kaqd_pkg::KEY_W-1:0] key,
  input  kaqd_pkg::qstate_t          qs,
  output logic                       hit
);
  import kaqd_pkg::*;

  // compare every lane of one queue row, live lanes only
  always_comb begin
    logic [SLOT_W:0] lane;
    logic [SLOT_W:0] off;
    hit = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lane = (SLOT_W+1)'(i);
      if (lane >= {1'b0, qs.head}) begin
        off = lane - {1'b0, qs.head};
      end else begin
        off = lane + (SLOT_W+1)'(QUEUE_DEPTH) - {1'b0, qs.head};
      end
      if (off < (SLOT_W+1)'(qs.count) && row[i*KEY_W +: KEY_W] == key) begin
        hit = 1'b1;
      end
    end
  end

endmodule

>>> sv/kaqd_least.sv
module kaqd_least (
  input  kaqd_pkg::qstate_t          qs [kaqd_pkg::NUM_QUEUES],
  input  logic [kaqd_pkg::SPAN_W-1:0] span,
  output logic [kaqd_pkg::QW-1:0]     idx
);
  import kaqd_pkg::*;

  // strict less-than keeps the lowest index on ties
  always_comb begin
    idx = '0;
    for (int q = 1; q < NUM_QUEUES; q++) begin
      if (SPAN_W'(q) < span && qs[q].count < qs[idx].count) begin
        idx = QW'(q);
      end
    end
  end

endmodule

>>> sv/key_affinity_queue_dispatch.sv
// keyed dispatcher over NUM_QUEUES bounded fifo queues, one item in flight at a time
// pop: key row and handle read, then S_POP and S_RESP; zero key or empty pop: S_RESP directly
// push: a key hit in the s-th scanned queue (s = 1..n) goes from S_SCAN to S_INSERT and S_RESP;
//   n = active queues; no hit: S_MIN rereads the emptiest row; one key-row read per queue scanned
// the next item is taken the cycle after its result is loaded into the output register
// rst (synchronous) empties all queues and sets active_queues to 4; stored entries are not cleared
module key_affinity_queue_dispatch (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [kaqd_pkg::ACT_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [kaqd_pkg::KEY_W-1:0]    item_key,
  input  logic [kaqd_pkg::HPORT_W-1:0]  item_handle,
  input  logic [kaqd_pkg::QPORT_W-1:0]  queue_sel,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [kaqd_pkg::QPORT_W-1:0]  queue_index,
  output logic [kaqd_pkg::KEY_W-1:0]    out_key,
  output logic [kaqd_pkg::HPORT_W-1:0]  out_handle
);
  import kaqd_pkg::*;

  state_t state, state_next;

  // queue pointers and config live in flops
  qstate_t            qs [NUM_QUEUES];
  logic [ACT_W-1:0]   active;
  logic [SPAN_W-1:0]  span;

  // latched item
  logic [KEY_W-1:0]   key_r;
  logic [HS_W-1:0]    handle_r;
  logic [QPORT_W-1:0] sel_r;
  logic [QW-1:0]      sel_q;
  logic [QW-1:0]      scan_q;
  logic [QW-1:0]      chosen;

  // pending result
  status_t             res_status;
  logic [QPORT_W-1:0]  res_qidx;
  logic [KEY_W-1:0]    res_key;
  logic [HPORT_W-1:0]  res_handle;

  // output register
  status_t             out_status;
  logic                out_free;

  // memories: one key row per queue, handles flat
  logic              kr_re, kw_we;
  logic [QW-1:0]     kr_raddr;
  logic [ROW_W-1:0]  kr_rdata, kw_data;
  logic              hr_re, hw_we;
  logic [HA_W-1:0]   hr_raddr, hw_waddr;
  logic [HS_W-1:0]   hr_rdata;

  // decode
  logic              accept;
  logic              sel_bad;
  logic [QW-1:0]     in_sel_q;
  logic              in_pop_empty;
  logic              hit;
  logic [QW-1:0]     least_idx;
  logic [SPAN_W:0]   scan_nxt;
  logic              ins_full;
  logic [SLOT_W:0]   tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] pop_head;

  function automatic logic [HA_W-1:0] slot_addr(input logic [QW-1:0] q,
                                                input logic [SLOT_W-1:0] lane);
    slot_addr = HA_W'(q) * HA_W'(QUEUE_DEPTH) + HA_W'(lane);
  endfunction

  // zero means one queue, anything above the queue count is clamped
  always_comb begin
    if (active == '0) begin
      span = SPAN_W'(1);
    end else if ((ACT_W+1)'(active) > (ACT_W+1)'(NUM_QUEUES)) begin
      span = SPAN_W'(NUM_QUEUES);
    end else begin
      span = SPAN_W'(active);
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign in_sel_q     = QW'(queue_sel);
  assign sel_bad      = (32'(queue_sel) >= 32'(NUM_QUEUES));
  assign in_pop_empty = sel_bad || (qs[in_sel_q].count == '0);
  assign sel_q        = QW'(sel_r);
  assign scan_nxt     = (SPAN_W+1)'(scan_q) + 1'b1;
  assign pop_head     = qs[sel_q].head;
  assign ins_full     = (qs[chosen].count >= CNT_W'(QUEUE_DEPTH));

  // slot behind the newest entry of the chosen queue
  always_comb begin
    tail_sum = {1'b0, qs[chosen].head} + (SLOT_W+1)'(qs[chosen].count);
    if (tail_sum >= (SLOT_W+1)'(QUEUE_DEPTH)) begin
      tail = SLOT_W'(tail_sum - (SLOT_W+1)'(QUEUE_DEPTH));
    end else begin
      tail = SLOT_W'(tail_sum);
    end
  end

  // read-modify-write: only the tail lane of the held row changes
  always_comb begin
    kw_data = kr_rdata;
    kw_data[tail*KEY_W +: KEY_W] = key_r;
  end

  assign hw_waddr = slot_addr(chosen, tail);

  kaqd_match u_match (
    .row (kr_rdata),
    .key (key_r),
    .qs  (qs[scan_q]),
    .hit (hit)
  );

  kaqd_least u_least (
    .qs   (qs),
    .span (span),
    .idx  (least_idx)
  );

  kaqd_ram #(.WIDTH(ROW_W), .DEPTH(NUM_QUEUES)) u_key_ram (
    .clk   (clk),
    .we    (kw_we),
    .waddr (chosen),
    .wdata (kw_data),
    .re    (kr_re),
    .raddr (kr_raddr),
    .rdata (kr_rdata)
  );

  kaqd_ram #(.WIDTH(HS_W), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_handle_ram (
    .clk   (clk),
    .we    (hw_we),
    .waddr (hw_waddr),
    .wdata (handle_r),
    .re    (hr_re),
    .raddr (hr_raddr),
    .rdata (hr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    kr_re      = 1'b0;
    kr_raddr   = '0;
    hr_re      = 1'b0;
    hr_raddr   = '0;
    kw_we      = 1'b0;
    hw_we      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_POP) begin
            if (in_pop_empty) begin
              state_next = S_RESP;
            end else begin
              kr_re      = 1'b1;
              kr_raddr   = in_sel_q;
              hr_re      = 1'b1;
              hr_raddr   = slot_addr(in_sel_q, qs[in_sel_q].head);
              state_next = S_POP;
            end
          end else if (item_key == '0) begin
            state_next = S_RESP;
          end else begin
            // start the key scan at queue zero
            kr_re      = 1'b1;
            kr_raddr   = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_POP: begin
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (hit) begin
          // row stays in the read register for the insert
          state_next = S_INSERT;
        end else if (scan_nxt < {1'b0, span}) begin
          kr_re      = 1'b1;
          kr_raddr   = QW'(scan_nxt);
        end else begin
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        kr_re      = 1'b1;
        kr_raddr   = least_idx;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        if (!ins_full) begin
          kw_we = 1'b1;
          hw_we = 1'b1;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers: queue pointers, config, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        qs[q] <= '0;
      end
      active    <= ACT_W'(ACT_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_data;
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_POP) begin
        if (pop_head == SLOT_W'(QUEUE_DEPTH - 1)) begin
          qs[sel_q].head <= '0;
        end else begin
          qs[sel_q].head <= pop_head + 1'b1;
        end
        qs[sel_q].count <= qs[sel_q].count - 1'b1;
      end
      if (state == S_INSERT && !ins_full) begin
        qs[chosen].count <= qs[chosen].count + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          key_r      <= item_key;
          handle_r   <= item_handle[HS_W-1:0];
          sel_r      <= queue_sel;
          scan_q     <= '0;
          res_key    <= '0;
          res_handle <= '0;
          if (op == OP_POP) begin
            res_status <= ST_EMPTY;
            res_qidx   <= queue_sel;
          end else begin
            res_status <= ST_ZERO_KEY;
            res_qidx   <= '0;
          end
        end
      end
      S_POP: begin
        res_status <= ST_DONE;
        res_qidx   <= sel_r;
        res_key    <= kr_rdata[pop_head*KEY_W +: KEY_W];
        res_handle <= HPORT_W'(hr_rdata);
      end
      S_SCAN: begin
        if (hit) begin
          chosen <= scan_q;
        end else begin
          scan_q <= QW'(scan_nxt);
        end
      end
      S_MIN: begin
        chosen <= least_idx;
      end
      S_INSERT: begin
        res_status <= ins_full ? ST_FULL : ST_DONE;
        res_qidx   <= QPORT_W'(chosen);
      end
      S_RESP: begin
        if (out_free) begin
          out_status  <= res_status;
          queue_index <= res_qidx;
          out_key     <= res_key;
          out_handle  <= res_handle;
        end
      end
      default: begin
      end
    endcase
  end

  assign status = out_status;

endmodule

>>> sv/kaqd_checker.sv
module kaqd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [kaqd_pkg::QPORT_W-1:0]  queue_index,
  input logic [kaqd_pkg::KEY_W-1:0]    out_key,
  input logic [kaqd_pkg::HPORT_W-1:0]  out_handle
);
  import kaqd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(queue_index)
      && $stable(out_key) && $stable(out_handle))
    else $error("result changed while stalled");

  // only a successful pop carries a key and handle
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> out_key == '0 && out_handle == '0)
    else $error("non-zero payload on a refused or empty result");

  a_zero_key_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZERO_KEY |-> queue_index == '0)
    else $error("zero key refusal names a queue");

  // one item at a time: the block is busy right after a transfer in
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind key_affinity_queue_dispatch kaqd_checker u_kaqd_checker (.*);
